FILE: src/rhcc_pkg.sv
// Shared codes for the RGB/HSV color converter.
package rhcc_pkg;

   // Conversion direction carried by each beat
   localparam logic MODE_TO_HSV = 1'b0;
   localparam logic MODE_TO_RGB = 1'b1;

   // Hue sectors, one sixth of a turn each
   typedef logic [2:0] sector_type;
   localparam sector_type SECTOR_RY = 3'd0;
   localparam sector_type SECTOR_YG = 3'd1;
   localparam sector_type SECTOR_GC = 3'd2;
   localparam sector_type SECTOR_CB = 3'd3;
   localparam sector_type SECTOR_BM = 3'd4;

endpackage

FILE: src/rgb_hsv_color_convert.sv
// Top level of the RGB/HSV color converter pipeline.
// Converts one pixel per clock unless the output stalls: mode 0 turns red, green, blue
// into hue, saturation, value; mode 1 turns hue, saturation, value into red, green, blue.
// A new beat is taken every cycle unless every stage is full and the output is stalled.
// Two restoring dividers, one quotient bit per stage over COMPONENT_BITS + 1 stages,
// produce hue and saturation, and in mode 1 the chroma S*V/full scale. Every stage
// carries its own valid bit, so a stalled output only holds the stages that are full.
module rgb_hsv_color_convert #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   input  logic [COMPONENT_BITS-1:0] req_comp_a,
   input  logic [COMPONENT_BITS-1:0] req_comp_b,
   input  logic [COMPONENT_BITS-1:0] req_comp_c,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COMPONENT_BITS-1:0] rsp_out_a,
   output logic [COMPONENT_BITS-1:0] rsp_out_b,
   output logic [COMPONENT_BITS-1:0] rsp_out_c
);
   import rhcc_pkg::*;

   localparam int CB = COMPONENT_BITS;
   localparam int K  = CB + 1;
   localparam int DW = CB + 3;
   localparam int NW = 2 * CB + 3;
   localparam logic [CB-1:0] FULL = {CB{1'b1}};

   typedef struct packed {
      logic [DW-1:0] rem;
      logic [K-1:0]  nlo;
      logic [DW-1:0] dvs;
      logic [K-1:0]  quo;
   } lane_type;

   typedef struct packed {
      logic          mode;
      logic          hue_zero;
      logic          sat_zero;
      logic [CB-1:0] val;
      logic [CB-1:0] frac;
      sector_type    sector;
   } side_type;

   // ---------------- handshake: per-stage advance
   logic           a_valid_ff, b_valid_ff, p_valid_ff, f_valid_ff;
   logic [K:0]     d_valid_ff;
   logic           adv_a, adv_b, adv_p, adv_f;
   logic [K:0]     adv_d;

   assign adv_f = !f_valid_ff || rsp_ready;
   assign adv_p = !p_valid_ff || adv_f;
   assign adv_d[K] = !d_valid_ff[K] || adv_p;
   genvar gi;
   generate
      for (gi = 0; gi < K; gi++) begin : g_adv
         assign adv_d[gi] = !d_valid_ff[gi] || adv_d[gi+1];
      end
   endgenerate
   assign adv_b = !b_valid_ff || adv_d[0];
   assign adv_a = !a_valid_ff || adv_b;
   assign req_ready = adv_a;

   // ---------------- stage A: capture the beat
   logic          a_mode_ff;
   logic [CB-1:0] a_x_ff, a_y_ff, a_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv_a) begin
         a_valid_ff <= req_valid;
      end
      if (adv_a) begin
         a_mode_ff <= req_mode;
         a_x_ff    <= req_comp_a;
         a_y_ff    <= req_comp_b;
         a_z_ff    <= req_comp_c;
      end
   end

   // ---------------- stage B: max, min, delta; S*V product; hue sector
   logic [CB-1:0]   mx, mn;
   logic            rmax_in, gmax_in;
   logic [CB+2:0]   turn6;
   logic            b_mode_ff, b_rmax_ff, b_gmax_ff;
   logic [CB-1:0]   b_r_ff, b_g_ff, b_b_ff, b_mx_ff, b_delta_ff, b_f_ff;
   logic [2*CB-1:0] b_p_ff;
   sector_type      b_sector_ff;

   always_comb begin
      mx = a_x_ff;
      mn = a_x_ff;
      if (a_y_ff > mx) mx = a_y_ff;
      if (a_z_ff > mx) mx = a_z_ff;
      if (a_y_ff < mn) mn = a_y_ff;
      if (a_z_ff < mn) mn = a_z_ff;
      rmax_in = (a_x_ff >= a_y_ff) && (a_x_ff >= a_z_ff);
      gmax_in = !rmax_in && (a_y_ff >= a_z_ff);
      turn6   = ({3'b000, a_x_ff} << 2) + ({3'b000, a_x_ff} << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv_b) begin
         b_valid_ff <= a_valid_ff;
      end
      if (adv_b) begin
         b_mode_ff   <= a_mode_ff;
         b_r_ff      <= a_x_ff;
         b_g_ff      <= a_y_ff;
         b_b_ff      <= a_z_ff;
         b_mx_ff     <= (a_mode_ff == MODE_TO_RGB) ? a_z_ff : mx;
         b_delta_ff  <= mx - mn;
         b_rmax_ff   <= rmax_in;
         b_gmax_ff   <= gmax_in;
         b_p_ff      <= {{CB{1'b0}}, a_y_ff} * {{CB{1'b0}}, a_z_ff};
         b_sector_ff <= turn6[CB+2:CB];
         b_f_ff      <= turn6[CB-1:0];
      end
   end

   // ---------------- stage C: set up both divider lanes
   logic [DW-1:0] d_ext, d6, hue_n;
   logic [NW-1:0] hue_num, sat_num;
   logic [DW-1:0] sat_dvs;
   lane_type      lane0_in, lane1_in;
   side_type      side_in;

   always_comb begin
      d_ext = {3'b000, b_delta_ff};
      d6    = (d_ext << 2) + (d_ext << 1);
      if (b_rmax_ff) begin
         if (b_g_ff >= b_b_ff) hue_n = {3'b000, b_g_ff - b_b_ff};
         else                  hue_n = d6 - {3'b000, b_b_ff - b_g_ff};
      end else if (b_gmax_ff) begin
         hue_n = (d_ext << 1) + {3'b000, b_b_ff} - {3'b000, b_r_ff};
      end else begin
         hue_n = (d_ext << 2) + {3'b000, b_r_ff} - {3'b000, b_g_ff};
      end
      hue_num = {hue_n, {CB{1'b0}}} + {{(NW-DW){1'b0}}, d6 >> 1};
      if (b_mode_ff == MODE_TO_RGB) begin
         sat_num = {3'b000, b_p_ff} + {{(CB+3){1'b0}}, FULL >> 1};
         sat_dvs = {3'b000, FULL};
      end else begin
         sat_num = ({{(CB+3){1'b0}}, b_delta_ff} << CB)
                 - {{(CB+3){1'b0}}, b_delta_ff}
                 + {{(CB+3){1'b0}}, b_mx_ff >> 1};
         sat_dvs = {3'b000, b_mx_ff};
      end
      lane0_in.rem = {1'b0, hue_num[NW-1:K]};
      lane0_in.nlo = hue_num[K-1:0];
      lane0_in.dvs = d6;
      lane0_in.quo = '0;
      lane1_in.rem = {1'b0, sat_num[NW-1:K]};
      lane1_in.nlo = sat_num[K-1:0];
      lane1_in.dvs = sat_dvs;
      lane1_in.quo = '0;
      side_in.mode     = b_mode_ff;
      side_in.hue_zero = (b_delta_ff == '0);
      side_in.sat_zero = (b_mx_ff == '0);
      side_in.val      = b_mx_ff;
      side_in.frac     = b_f_ff;
      side_in.sector   = b_sector_ff;
   end

   // ---------------- divider stages: one quotient bit per stage
   lane_type lane0_ff [0:K];
   lane_type lane1_ff [0:K];
   side_type side_ff  [0:K];

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff[0] <= 1'b0;
      end else if (adv_d[0]) begin
         d_valid_ff[0] <= b_valid_ff;
      end
      if (adv_d[0]) begin
         lane0_ff[0] <= lane0_in;
         lane1_ff[0] <= lane1_in;
         side_ff[0]  <= side_in;
      end
   end

   generate
      for (gi = 0; gi < K; gi++) begin : g_div
         logic [DW-1:0] rem0_in, rem1_in;
         logic          q0_in, q1_in;

         rhcc_div_step #(.DW(DW)) u_step0 (
            .rem(lane0_ff[gi].rem), .nbit(lane0_ff[gi].nlo[K-1]),
            .divisor(lane0_ff[gi].dvs), .rem_out(rem0_in), .qbit(q0_in)
         );
         rhcc_div_step #(.DW(DW)) u_step1 (
            .rem(lane1_ff[gi].rem), .nbit(lane1_ff[gi].nlo[K-1]),
            .divisor(lane1_ff[gi].dvs), .rem_out(rem1_in), .qbit(q1_in)
         );

         // Advance the partial remainders and quotients
         always_ff @(posedge clock) begin
            if (reset) begin
               d_valid_ff[gi+1] <= 1'b0;
            end else if (adv_d[gi+1]) begin
               d_valid_ff[gi+1] <= d_valid_ff[gi];
            end
            if (adv_d[gi+1]) begin
               lane0_ff[gi+1].rem <= rem0_in;
               lane0_ff[gi+1].nlo <= lane0_ff[gi].nlo << 1;
               lane0_ff[gi+1].dvs <= lane0_ff[gi].dvs;
               lane0_ff[gi+1].quo <= {lane0_ff[gi].quo[K-2:0], q0_in};
               lane1_ff[gi+1].rem <= rem1_in;
               lane1_ff[gi+1].nlo <= lane1_ff[gi].nlo << 1;
               lane1_ff[gi+1].dvs <= lane1_ff[gi].dvs;
               lane1_ff[gi+1].quo <= {lane1_ff[gi].quo[K-2:0], q1_in};
               side_ff[gi+1]      <= side_ff[gi];
            end
         end
      end
   endgenerate

   // ---------------- stage P: hue/saturation select; chroma times fraction
   side_type        sd;
   logic [CB-1:0]   chroma;
   logic [CB:0]     fac;
   logic            p_mode_ff;
   logic [CB-1:0]   p_hue_ff, p_sat_ff, p_val_ff, p_c_ff;
   sector_type      p_sector_ff;
   logic [2*CB:0]   p_prod_ff;

   always_comb begin
      sd     = side_ff[K];
      chroma = lane1_ff[K].quo[CB-1:0];
      if (chroma > sd.val) chroma = sd.val;
      if (sd.sector[0]) fac = {1'b1, {CB{1'b0}}} - {1'b0, sd.frac};
      else              fac = {1'b0, sd.frac};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv_p) begin
         p_valid_ff <= d_valid_ff[K];
      end
      if (adv_p) begin
         p_mode_ff   <= sd.mode;
         p_hue_ff    <= sd.hue_zero ? '0 : lane0_ff[K].quo[CB-1:0];
         p_sat_ff    <= sd.sat_zero ? '0 : lane1_ff[K].quo[CB-1:0];
         p_val_ff    <= sd.val;
         p_c_ff      <= chroma;
         p_sector_ff <= sd.sector;
         p_prod_ff   <= {{(CB+1){1'b0}}, chroma} * {{CB{1'b0}}, fac};
      end
   end

   // ---------------- stage F: round X, add the offset, place by sector
   logic [2*CB+1:0] xsum;
   logic [CB-1:0]   xv, mv, ra, ga, ba;
   logic [CB-1:0]   f_a_ff, f_b_ff, f_c_ff;

   always_comb begin
      xsum = {1'b0, p_prod_ff} + ({{(2*CB+1){1'b0}}, 1'b1} << (CB - 1));
      xv   = xsum[2*CB-1:CB];
      mv   = p_val_ff - p_c_ff;
      ra   = '0;
      ga   = '0;
      ba   = '0;
      case (p_sector_ff)
         SECTOR_RY: begin ra = p_c_ff; ga = xv;     end
         SECTOR_YG: begin ra = xv;     ga = p_c_ff; end
         SECTOR_GC: begin ga = p_c_ff; ba = xv;     end
         SECTOR_CB: begin ga = xv;     ba = p_c_ff; end
         SECTOR_BM: begin ra = xv;     ba = p_c_ff; end
         default:   begin ra = p_c_ff; ba = xv;     end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv_f) begin
         f_valid_ff <= p_valid_ff;
      end
      if (adv_f) begin
         if (p_mode_ff == MODE_TO_RGB) begin
            f_a_ff <= ra + mv;
            f_b_ff <= ga + mv;
            f_c_ff <= ba + mv;
         end else begin
            f_a_ff <= p_hue_ff;
            f_b_ff <= p_sat_ff;
            f_c_ff <= p_val_ff;
         end
      end
   end

   assign rsp_valid = f_valid_ff;
   assign rsp_out_a = f_a_ff;
   assign rsp_out_b = f_b_ff;
   assign rsp_out_c = f_c_ff;
endmodule

FILE: src/rhcc_div_step.sv
// One restoring-division step: shift in a numerator bit, compare, subtract.
module rhcc_div_step #(
   parameter int DW = 19
) (
   input  logic [DW-1:0] rem,
   input  logic          nbit,
   input  logic [DW-1:0] divisor,
   output logic [DW-1:0] rem_out,
   output logic          qbit
);
   logic [DW:0] trial;
   logic [DW:0] diff;

   // Subtract the divisor when the shifted remainder covers it
   assign trial   = {rem, nbit};
   assign diff    = trial - {1'b0, divisor};
   assign qbit    = (trial >= {1'b0, divisor});
   assign rem_out = qbit ? diff[DW-1:0] : trial[DW-1:0];
endmodule

FILE: src/rhcc_checker.sv
// Port-level checks for the RGB/HSV color converter, bound to the top level.
module rhcc_checker #(
   parameter int COMPONENT_BITS = 16
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [COMPONENT_BITS-1:0] rsp_out_a,
   input logic [COMPONENT_BITS-1:0] rsp_out_b,
   input logic [COMPONENT_BITS-1:0] rsp_out_c
);
   localparam int EMPTY_CYCLES = COMPONENT_BITS + 5;

   // Hold a stalled result beat
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_a) && $stable(rsp_out_b)
                                  && $stable(rsp_out_c))
      else $error("result beat changed while stalled");

   // An open output stage lets the whole pipe advance
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while output stage is open");

   // No result can come out sooner than the pipeline depth after reset
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $past(reset, EMPTY_CYCLES) |-> !rsp_valid)
      else $error("result beat before pipeline could fill");

   // Reset empties the output stage
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind rgb_hsv_color_convert rhcc_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_rhcc_checker (.*);
